@@ sv/ctls_pkg.sv @@
// Shared types, codes and constants of the cyclic tridiagonal LU solver.
// Used by ctls_div, cyclic_tridiagonal_lu_solver and its checker; no dependencies.
package ctls_pkg;

  localparam int DEF_MAX_ORDER = 64;
  localparam int DEF_FRAC_BITS = 24;
  localparam int VAL_W = 32;
  localparam int ORDER_W = 7;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 7'd64;
  localparam logic [ORDER_W-1:0] ORDER_MIN = 7'd3;

  // Operation codes of an input item.
  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_FACTOR    = 2'd1;
  localparam logic [1:0] OP_LOAD_RHS  = 2'd2;
  localparam logic [1:0] OP_SOLVE     = 2'd3;

  // Store codes; the right-hand side shares the memory as a sixth store.
  localparam logic [2:0] ST_LOWER  = 3'd0;
  localparam logic [2:0] ST_MAIN   = 3'd1;
  localparam logic [2:0] ST_UPPER  = 3'd2;
  localparam logic [2:0] ST_BOTTOM = 3'd3;
  localparam logic [2:0] ST_RIGHT  = 3'd4;
  localparam logic [2:0] ST_RHS    = 3'd5;

  // Error codes of a result.
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_ZERO_DIV = 2'd1;
  localparam logic [1:0] ERR_SAT      = 2'd2;

  // Result kinds.
  localparam logic KIND_FACTOR   = 1'b0;
  localparam logic KIND_SOLUTION = 1'b1;

  typedef struct packed {
    logic [1:0]              opcode;
    logic [2:0]              store_select;
    logic [5:0]              element_index;
    logic signed [VAL_W-1:0] element_value;
  } ctls_in_t;

  typedef struct packed {
    logic                    result_kind;
    logic [5:0]              result_index;
    logic signed [VAL_W-1:0] result_value;
    logic                    last_element;
    logic [1:0]              error_code;
  } ctls_out_t;

  // Request to and response from the divider.
  typedef struct packed {
    logic                    start;
    logic signed [VAL_W-1:0] dividend;
    logic signed [VAL_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quotient;
    logic                    sat;
    logic                    zero;
  } div_rsp_t;

  // Error code from the flags: zero divisor wins over saturation.
  function automatic logic [1:0] code_of(input logic zero_flag, input logic sat_flag);
    logic [1:0] c;
    c = ERR_NONE;
    if (zero_flag) begin
      c = ERR_ZERO_DIV;
    end else if (sat_flag) begin
      c = ERR_SAT;
    end
    return c;
  endfunction

endpackage

@@ sv/ctls_div.sv @@
// Fixed-point divider: (x * 2^FRAC_BITS) / y truncated toward zero, saturated.
// Restoring, one quotient bit per cycle. Depends on ctls_pkg.
module ctls_div
  import ctls_pkg::*;
#(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DVD_W = VAL_W + FRAC_BITS;
  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] QMAX = DVD_W'(64'h7fff_ffff);
  localparam logic [DVD_W-1:0] QMIN_MAG = DVD_W'(64'h8000_0000);

  logic             busy_r, fin_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] dvd_r;
  logic [VAL_W-1:0] rem_r, den_r;
  logic             neg_r, xneg_r, zero_r;
  logic [VAL_W-1:0] abs_x, abs_y;
  logic [VAL_W:0]   trial;
  logic             ge;

  assign abs_x = req.dividend[VAL_W-1] ? (~req.dividend + 1'b1) : req.dividend;
  assign abs_y = req.divisor[VAL_W-1] ? (~req.divisor + 1'b1) : req.divisor;
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  // Control: busy while bits remain, then a one-cycle done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      if (req.start) begin
        busy_r <= (req.divisor != '0);
        fin_r  <= (req.divisor == '0);
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end else begin
        fin_r <= 1'b0;
      end
    end
  end

  // Datapath: the quotient shifts in where the dividend shifts out.
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r  <= {abs_x, {FRAC_BITS{1'b0}}};
      den_r  <= abs_y;
      rem_r  <= '0;
      cnt_r  <= CNT_W'(DVD_W);
      neg_r  <= req.dividend[VAL_W-1] ^ req.divisor[VAL_W-1];
      xneg_r <= req.dividend[VAL_W-1];
      zero_r <= (req.divisor == '0);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      rem_r <= ge ? VAL_W'(trial - {1'b0, den_r}) : trial[VAL_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
  end

  // Sign and saturation of the finished quotient.
  always_comb begin
    rsp.done = fin_r;
    rsp.sat  = 1'b0;
    rsp.zero = zero_r;
    if (zero_r) begin
      rsp.quotient = xneg_r ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else if (!neg_r) begin
      if (dvd_r > QMAX) begin
        rsp.quotient = 32'sh7fff_ffff;
        rsp.sat      = 1'b1;
      end else begin
        rsp.quotient = dvd_r[VAL_W-1:0];
      end
    end else begin
      if (dvd_r > QMIN_MAG) begin
        rsp.quotient = 32'sh8000_0000;
        rsp.sat      = 1'b1;
      end else begin
        rsp.quotient = ~dvd_r[VAL_W-1:0] + 1'b1;
      end
    end
  end

endmodule

@@ sv/cyclic_tridiagonal_lu_solver.sv @@
// Loads write the memory directly and produce no result. Factor and solve run as
// operations on one shared memory: a multiply-subtract does three reads, a multiply
// and a write, a divide the reads, a division and a write. Factor: (n-2) passes of
// four multiply-subtracts and two divides, then one divide, one multiply-subtract
// and a report. Solve: 4n-6 multiply-subtracts and n divides, then n results.
// Synchronous active-low reset clears control and flags; order resets to 64.
module cyclic_tridiagonal_lu_solver
  import ctls_pkg::*;
#(
  parameter int MAX_ORDER = DEF_MAX_ORDER,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ctls_in_t           in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ctls_out_t          out_data,
  input  logic               cfg_we,
  input  logic [ORDER_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int ADDR_W = 3 + IDX_W;
  localparam int MEM_DEPTH = 6 * (1 << IDX_W);
  localparam int STEP_W = 3;

  // Sequencer states.
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RD_Y    = 4'd1;
  localparam logic [3:0] S_RD_Z    = 4'd2;
  localparam logic [3:0] S_RD_X    = 4'd3;
  localparam logic [3:0] S_CAP_X   = 4'd4;
  localparam logic [3:0] S_ACC     = 4'd5;
  localparam logic [3:0] S_DIV     = 4'd6;
  localparam logic [3:0] S_EMIT_RD = 4'd7;
  localparam logic [3:0] S_EMIT_WR = 4'd8;
  localparam logic [3:0] S_REPORT  = 4'd9;

  // Phases of the factor and solve programs.
  localparam logic [2:0] PH_F_LOOP = 3'd0;
  localparam logic [2:0] PH_F_TAIL = 3'd1;
  localparam logic [2:0] PH_S_FWD  = 3'd2;
  localparam logic [2:0] PH_S_DIV  = 3'd3;
  localparam logic [2:0] PH_S_BACK = 3'd4;

  logic [3:0]        state_r, state_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [IDX_W-1:0]  k_r, k_nxt;
  logic [IDX_W-1:0]  last_r, pen_r;
  logic [ORDER_W-1:0] order_r;
  logic              zflag_r, sflag_r;

  logic signed [VAL_W-1:0] mem [MEM_DEPTH];
  logic signed [VAL_W-1:0] rd_data_r;
  logic signed [VAL_W-1:0] x_r, y_r, z_r;
  logic signed [63:0]      prod_r;
  logic                    out_valid_r;
  ctls_out_t               out_data_r;

  logic [ADDR_W-1:0] rd_addr, wr_addr, xa, ya, za;
  logic              wr_en;
  logic signed [VAL_W-1:0] wr_data;
  logic              op_div, op_skip, advance;
  logic [2:0]        ph_adv;
  logic [STEP_W-1:0] step_adv;
  logic [IDX_W-1:0]  k_adv, nx;
  logic [3:0]        st_adv;
  logic              in_xfer, load_ok, slot_free;
  logic [ORDER_W-1:0] n_clamped;
  logic signed [63:0] rnd, diff;
  logic              mac_sat;
  logic signed [VAL_W-1:0] mac_res;
  div_req_t          dreq;
  div_rsp_t          drsp;

  function automatic logic [ADDR_W-1:0] addr_of(input logic [2:0] st, input logic [IDX_W-1:0] i);
    return {st, i};
  endfunction

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign nx        = k_r + 1'b1;

  // Order register, clamped when a program starts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_RESET;
    end else if (cfg_we) begin
      order_r <= cfg_wdata;
    end
  end

  always_comb begin
    n_clamped = order_r;
    if (order_r < ORDER_MIN) begin
      n_clamped = ORDER_MIN;
    end else if (order_r > ORDER_W'(MAX_ORDER)) begin
      n_clamped = ORDER_W'(MAX_ORDER);
    end
  end

  // Operation decode: destination x, operands y and z for the current step.
  always_comb begin
    op_div  = 1'b0;
    op_skip = 1'b0;
    xa = addr_of(ST_RHS, k_r);
    ya = addr_of(ST_MAIN, k_r);
    za = addr_of(ST_MAIN, k_r);
    case (phase_r)
      PH_F_LOOP: begin
        case (step_r)
          3'd0: begin
            op_div = 1'b1;
            xa = addr_of(ST_LOWER, nx);
            ya = addr_of(ST_MAIN, k_r);
          end
          3'd1: begin
            xa = addr_of(ST_MAIN, nx);
            ya = addr_of(ST_LOWER, nx);
            za = addr_of(ST_UPPER, k_r);
          end
          3'd2: begin
            xa = (nx < pen_r) ? addr_of(ST_RIGHT, nx) : addr_of(ST_UPPER, nx);
            ya = addr_of(ST_LOWER, nx);
            za = addr_of(ST_RIGHT, k_r);
          end
          3'd3: begin
            op_div = 1'b1;
            xa = addr_of(ST_BOTTOM, k_r);
            ya = addr_of(ST_MAIN, k_r);
          end
          3'd4: begin
            xa = (nx < pen_r) ? addr_of(ST_BOTTOM, nx) : addr_of(ST_LOWER, last_r);
            ya = addr_of(ST_BOTTOM, k_r);
            za = addr_of(ST_UPPER, k_r);
          end
          default: begin
            xa = addr_of(ST_MAIN, last_r);
            ya = addr_of(ST_BOTTOM, k_r);
            za = addr_of(ST_RIGHT, k_r);
          end
        endcase
      end
      PH_F_TAIL: begin
        if (step_r == 3'd0) begin
          op_div = 1'b1;
          xa = addr_of(ST_LOWER, last_r);
          ya = addr_of(ST_MAIN, pen_r);
        end else begin
          xa = addr_of(ST_MAIN, last_r);
          ya = addr_of(ST_LOWER, last_r);
          za = addr_of(ST_UPPER, pen_r);
        end
      end
      PH_S_FWD: begin
        if (step_r == 3'd0) begin
          xa = addr_of(ST_RHS, nx);
          ya = addr_of(ST_LOWER, nx);
          za = addr_of(ST_RHS, k_r);
        end else begin
          op_skip = (nx == last_r);
          xa = addr_of(ST_RHS, last_r);
          ya = addr_of(ST_BOTTOM, k_r);
          za = addr_of(ST_RHS, k_r);
        end
      end
      PH_S_DIV: begin
        op_div = 1'b1;
        xa = addr_of(ST_RHS, last_r);
        ya = addr_of(ST_MAIN, last_r);
      end
      PH_S_BACK: begin
        case (step_r)
          3'd0: begin
            xa = addr_of(ST_RHS, k_r);
            ya = addr_of(ST_UPPER, k_r);
            za = addr_of(ST_RHS, nx);
          end
          3'd1: begin
            op_skip = (nx == last_r);
            xa = addr_of(ST_RHS, k_r);
            ya = addr_of(ST_RIGHT, k_r);
            za = addr_of(ST_RHS, last_r);
          end
          default: begin
            op_div = 1'b1;
            xa = addr_of(ST_RHS, k_r);
            ya = addr_of(ST_MAIN, k_r);
          end
        endcase
      end
      default: begin
        op_skip = 1'b1;
      end
    endcase
  end

  // Program counter: the step that follows the current operation.
  always_comb begin
    ph_adv   = phase_r;
    step_adv = step_r + 1'b1;
    k_adv    = k_r;
    st_adv   = S_RD_Y;
    case (phase_r)
      PH_F_LOOP: begin
        if (step_r == 3'd5) begin
          step_adv = '0;
          k_adv    = nx;
          if (nx == pen_r) begin
            ph_adv = PH_F_TAIL;
          end
        end
      end
      PH_F_TAIL: begin
        if (step_r == 3'd1) begin
          st_adv = S_REPORT;
        end
      end
      PH_S_FWD: begin
        if (step_r == 3'd1) begin
          step_adv = '0;
          k_adv    = nx;
          if (nx == last_r) begin
            ph_adv = PH_S_DIV;
          end
        end
      end
      PH_S_DIV: begin
        ph_adv   = PH_S_BACK;
        step_adv = '0;
        k_adv    = last_r - 1'b1;
      end
      PH_S_BACK: begin
        if (step_r == 3'd2) begin
          step_adv = '0;
          k_adv    = k_r - 1'b1;
          if (k_r == '0) begin
            st_adv = S_EMIT_RD;
            k_adv  = '0;
          end
        end
      end
      default: begin
        st_adv = S_IDLE;
      end
    endcase
  end

  // Multiply-subtract: round the product, subtract, saturate to 32 bits.
  always_comb begin
    rnd     = (prod_r + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    diff    = 64'(x_r) - rnd;
    mac_sat = (diff[63:VAL_W-1] != '0) && (diff[63:VAL_W-1] != '1);
    if (!mac_sat) begin
      mac_res = diff[VAL_W-1:0];
    end else if (diff[63]) begin
      mac_res = 32'sh8000_0000;
    end else begin
      mac_res = 32'sh7fff_ffff;
    end
  end

  assign dreq.start    = (state_r == S_CAP_X) && op_div;
  assign dreq.dividend = rd_data_r;
  assign dreq.divisor  = y_r;

  ctls_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  // Sequencer next state and memory port selection.
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    step_nxt  = step_r;
    k_nxt     = k_r;
    rd_addr   = ya;
    advance   = 1'b0;
    load_ok   = 1'b0;
    wr_en     = 1'b0;
    wr_addr   = xa;
    wr_data   = mac_res;
    case (state_r)
      S_IDLE: begin
        load_ok = ({1'b0, in_data.element_index} < 7'(MAX_ORDER)) &&
                  (in_data.opcode == OP_LOAD_RHS ||
                   (in_data.opcode == OP_LOAD_COEF && in_data.store_select <= ST_RIGHT));
        wr_en   = in_xfer && load_ok;
        wr_addr = addr_of((in_data.opcode == OP_LOAD_RHS) ? ST_RHS : in_data.store_select,
                          in_data.element_index[IDX_W-1:0]);
        wr_data = in_data.element_value;
        if (in_xfer && in_data.opcode == OP_FACTOR) begin
          state_nxt = S_RD_Y;
          phase_nxt = PH_F_LOOP;
          step_nxt  = '0;
          k_nxt     = '0;
        end else if (in_xfer && in_data.opcode == OP_SOLVE) begin
          state_nxt = S_RD_Y;
          phase_nxt = PH_S_FWD;
          step_nxt  = '0;
          k_nxt     = '0;
        end
      end
      S_RD_Y: begin
        rd_addr = ya;
        if (op_skip) begin
          advance = 1'b1;
        end else begin
          state_nxt = S_RD_Z;
        end
      end
      S_RD_Z: begin
        rd_addr   = za;
        state_nxt = S_RD_X;
      end
      S_RD_X: begin
        rd_addr   = xa;
        state_nxt = S_CAP_X;
      end
      S_CAP_X: begin
        state_nxt = op_div ? S_DIV : S_ACC;
      end
      S_ACC: begin
        wr_en   = 1'b1;
        advance = 1'b1;
      end
      S_DIV: begin
        wr_data = drsp.quotient;
        if (drsp.done) begin
          wr_en   = 1'b1;
          advance = 1'b1;
        end
      end
      S_EMIT_RD: begin
        rd_addr   = addr_of(ST_RHS, k_r);
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        rd_addr = addr_of(ST_RHS, k_r);
        if (slot_free) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = (k_r == last_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (advance) begin
      state_nxt = st_adv;
      phase_nxt = ph_adv;
      step_nxt  = step_adv;
      k_nxt     = k_adv;
    end
  end

  // Control registers and error flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_F_LOOP;
      step_r      <= '0;
      k_r         <= '0;
      zflag_r     <= 1'b0;
      sflag_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
      k_r     <= k_nxt;
      if (in_xfer && (in_data.opcode == OP_FACTOR || in_data.opcode == OP_SOLVE)) begin
        zflag_r <= 1'b0;
        sflag_r <= 1'b0;
      end else if (state_r == S_ACC) begin
        sflag_r <= sflag_r | mac_sat;
      end else if (state_r == S_DIV && drsp.done) begin
        zflag_r <= zflag_r | drsp.zero;
        sflag_r <= sflag_r | drsp.sat;
      end
      if ((state_r == S_EMIT_WR || state_r == S_REPORT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Order bounds latched on every accepted input item, loads included.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      last_r <= IDX_W'(n_clamped - 1'b1);
      pen_r  <= IDX_W'(n_clamped - 2'd2);
    end
  end

  // Shared coefficient and right-hand-side memory, one read and one write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Operand capture and product register.
  always_ff @(posedge clk) begin
    if (state_r == S_RD_Z) begin
      y_r <= rd_data_r;
    end
    if (state_r == S_RD_X) begin
      z_r <= rd_data_r;
    end
    if (state_r == S_CAP_X) begin
      x_r    <= rd_data_r;
      prod_r <= y_r * z_r;
    end
  end

  // Output register: factor report or one solution element per transfer.
  always_ff @(posedge clk) begin
    if (state_r == S_EMIT_WR && slot_free) begin
      out_data_r.result_kind  <= KIND_SOLUTION;
      out_data_r.result_index <= 6'(k_r);
      out_data_r.result_value <= rd_data_r;
      out_data_r.last_element <= (k_r == last_r);
      out_data_r.error_code   <= code_of(zflag_r, sflag_r);
    end else if (state_r == S_REPORT && slot_free) begin
      out_data_r.result_kind  <= KIND_FACTOR;
      out_data_r.result_index <= '0;
      out_data_r.result_value <= '0;
      out_data_r.last_element <= 1'b1;
      out_data_r.error_code   <= code_of(zflag_r, sflag_r);
    end
  end

endmodule

@@ sv/ctls_checker.sv @@
// Port-level checks of the cyclic tridiagonal LU solver, bound to the top level.
// Depends on ctls_pkg and cyclic_tridiagonal_lu_solver.
module ctls_checker
  import ctls_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input ctls_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input ctls_out_t out_data
);

  // A stalled result transfer holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Factor and solve occupy the block after their transfer.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_FACTOR || in_data.opcode == OP_SOLVE)
    |=> !in_ready)
    else $error("input taken during factor or solve");

  // Loads keep the block ready.
  a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.opcode == OP_LOAD_COEF || in_data.opcode == OP_LOAD_RHS)
    |=> in_ready)
    else $error("load stalled the block");

  // A factor report is a single last item at index zero.
  a_report: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.result_kind == KIND_FACTOR
    |-> out_data.last_element && out_data.result_index == '0)
    else $error("malformed factor report");

endmodule

bind cyclic_tridiagonal_lu_solver ctls_checker u_ctls_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);
